// ===== sv/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, constants and types for the Newton square root unit.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_ITER  = 40;

  localparam int RAD_W    = 32;
  localparam int ROOT_W   = 25;
  localparam int SCALED_W = RAD_W + FRAC_BITS;   // radicand << FRAC_BITS
  localparam int PASS_W   = $clog2(MAX_ITER + 1);
  localparam int DCNT_W   = $clog2(SCALED_W + 1);

  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

  typedef logic [SCALED_W-1:0] wide_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UPD,
    S_CHK,
    S_FIN
  } nsr_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/nsr_in_if.sv =====
// ----------------------------------------------------------------------------
// nsr_in_if
// Request channel carrying one radicand.
// ----------------------------------------------------------------------------
interface nsr_in_if;

  logic                       valid;
  logic                       ready;
  logic [nsr_pkg::RAD_W-1:0]  radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);

endinterface

// ===== sv/nsr_out_if.sv =====
// ----------------------------------------------------------------------------
// nsr_out_if
// Result channel carrying the root and the iteration limit flag.
// ----------------------------------------------------------------------------
interface nsr_out_if;

  logic                       valid;
  logic                       ready;
  logic [nsr_pkg::ROOT_W-1:0] root;
  logic                       hit_limit;

  modport source (output valid, output root, output hit_limit, input ready);
  modport sink   (input valid, input root, input hit_limit, output ready);

endinterface

// ===== sv/nsr_div.sv =====
// ----------------------------------------------------------------------------
// nsr_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nsr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  nsr_pkg::div_ctrl_t ctrl,
  input  nsr_pkg::wide_t     dividend,
  input  nsr_pkg::wide_t     divisor,
  output nsr_pkg::div_stat_t stat,
  output nsr_pkg::wide_t     quotient
);
  import nsr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  wide_t             rem_r, rem_nxt;
  wide_t             quo_r, quo_nxt;
  wide_t             dsr_r;

  logic [SCALED_W:0] trial;
  logic [SCALED_W:0] trial_diff;
  logic              qbit;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial      = {rem_r, quo_r[SCALED_W-1]};
    trial_diff = trial - {1'b0, dsr_r};
    qbit       = ~trial_diff[SCALED_W];
    rem_nxt    = qbit ? trial_diff[SCALED_W-1:0] : trial[SCALED_W-1:0];
    quo_nxt    = {quo_r[SCALED_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(SCALED_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== sv/newton_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// newton_square_root_unit
// Fixed-point Newton-Raphson square root with a bit-serial divider.
// ----------------------------------------------------------------------------
// Takes one unsigned Q16.16 radicand per request and returns its Q16.16 root
// and a flag raised when 40 Newton passes ran without the estimate settling
// to within one LSB. One request is worked on at a time. A zero radicand
// finishes without a divide. Otherwise each Newton pass starts the
// one-bit-per-cycle divider on the 48-bit scaled radicand, then runs an
// estimate update and a convergence check; a request takes 1 to 40
// passes. A finished result waits in the output register while the next
// request is accepted.
module newton_square_root_unit (
  input  logic  clk,
  input  logic  rst_n,
  nsr_in_if.sink    in_ch,
  nsr_out_if.source out_ch
);
  import nsr_pkg::*;

  nsr_state_t        state_r, state_nxt;
  logic [PASS_W-1:0] pass_r;
  wide_t             scaled_r;
  wide_t             est_r;
  wide_t             nxt_r;
  logic [ROOT_W-1:0] res_root_r;
  logic              res_hit_r;

  logic              out_valid_r;
  logic [ROOT_W-1:0] out_root_r;
  logic              out_hit_r;

  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  wide_t             div_dividend;
  wide_t             div_divisor;
  wide_t             div_quo;

  logic              in_ready_c;
  logic              out_load_c;
  logic              in_take;
  logic              rad_zero;

  logic [SCALED_W:0] est_sum;
  wide_t             est_half;
  wide_t             est_new;
  wide_t             est_delta;
  logic              settled;
  logic              last_pass;
  logic [ROOT_W-1:0] root_sat;

  assign in_take  = in_ch.valid && in_ready_c;
  assign rad_zero = (in_ch.radicand == '0);

  // estimate update: (est + q) >> 1, never zero
  always_comb begin
    est_sum  = {1'b0, est_r} + {1'b0, div_quo};
    est_half = est_sum[SCALED_W:1];
    est_new  = (est_half == '0) ? SCALED_W'(1) : est_half;
  end

  // |new - est| <= 1 from one modular subtract
  always_comb begin
    est_delta = nxt_r - est_r;
    settled   = (est_delta == '0) || (est_delta == SCALED_W'(1)) || (est_delta == '1);
    last_pass = (pass_r == PASS_W'(MAX_ITER - 1));
    root_sat  = (|nxt_r[SCALED_W-1:ROOT_W]) ? ROOT_MAX : nxt_r[ROOT_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = rad_zero ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) state_nxt = S_UPD;
      end
      S_UPD: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = (settled || last_pass) ? S_FIN : S_DIV;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_c     = 1'b0;
    out_load_c     = 1'b0;
    div_ctrl.start = 1'b0;
    div_dividend   = scaled_r;
    div_divisor    = nxt_r;
    case (state_r)
      S_IDLE: begin
        in_ready_c     = 1'b1;
        div_ctrl.start = in_ch.valid && !rad_zero;
        div_dividend   = {in_ch.radicand, FRAC_BITS'(0)};
        div_divisor    = SCALED_W'(1) << FRAC_BITS;
      end
      S_CHK: begin
        div_ctrl.start = !(settled || last_pass);
      end
      S_FIN: begin
        out_load_c = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        pass_r <= '0;
      end else if (state_r == S_CHK && !(settled || last_pass)) begin
        pass_r <= pass_r + PASS_W'(1);
      end
      if (out_load_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      scaled_r   <= {in_ch.radicand, FRAC_BITS'(0)};
      est_r      <= SCALED_W'(1) << FRAC_BITS;
      res_root_r <= '0;
      res_hit_r  <= 1'b0;
    end
    if (state_r == S_UPD) begin
      nxt_r <= est_new;
    end
    if (state_r == S_CHK) begin
      est_r      <= nxt_r;
      res_root_r <= root_sat;
      res_hit_r  <= !settled;
    end
    if (out_load_c) begin
      out_root_r <= res_root_r;
      out_hit_r  <= res_hit_r;
    end
  end

  nsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_ch.ready      = in_ready_c;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.root      = out_root_r;
  assign out_ch.hit_limit = out_hit_r;

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r < PASS_W'(MAX_ITER))
    else $error("pass counter beyond iteration cap");

  a_take_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_DIV || state_r == S_FIN))
    else $error("accepted request not dispatched");

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

endmodule
